// ===== sv/modular_vector_alu_macros.svh =====
// Assertion macros shared by the modular vector ALU RTL.
// Needs clk and rst_n in the scope where a macro is used.
`ifndef MODULAR_VECTOR_ALU_MACROS_SVH
`define MODULAR_VECTOR_ALU_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define MVA_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define MVA_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/mva_pkg.sv =====
// Package for the modular vector ALU: operation codes, register indexes,
// the per-item control struct and default parameter values. No dependencies.
package mva_pkg;

    localparam int WORD_BITS_DEF = 64;
    localparam int CFG_INDEX_BITS = 8;

    typedef enum logic [2:0] {
        FUNC_NEG    = 3'd0,
        FUNC_SUB    = 3'd1,
        FUNC_ADD    = 3'd2,
        FUNC_RSUB   = 3'd3,
        FUNC_NEGSUM = 3'd4,
        FUNC_MUL    = 3'd5
    } func_t;

    localparam logic [CFG_INDEX_BITS-1:0] REG_MODULUS    = 8'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_MULTIPLIER = 8'd1;

    // Control fields that travel with each item down the pipeline.
    typedef struct packed {
        logic       valid;
        logic [2:0] func;
        logic       last;
    } mva_ctl_t;

endpackage

// ===== sv/mva_red_stage.sv =====
// One bit step of the operand reduction pipeline (a, b and x mod m).
// Depends on mva_pkg.
module mva_red_stage #(
    parameter int WORD_BITS = mva_pkg::WORD_BITS_DEF,
    parameter int BIT_POS = 0
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic [WORD_BITS-1:0] modulus,
    input  logic [WORD_BITS-1:0] x_src,
    input  mva_pkg::mva_ctl_t    ctl_in,
    input  logic [WORD_BITS-1:0] a_src_in,
    input  logic [WORD_BITS-1:0] b_src_in,
    input  logic [WORD_BITS-1:0] a_rem_in,
    input  logic [WORD_BITS-1:0] b_rem_in,
    input  logic [WORD_BITS-1:0] x_rem_in,
    output mva_pkg::mva_ctl_t    ctl_out,
    output logic [WORD_BITS-1:0] a_src_out,
    output logic [WORD_BITS-1:0] b_src_out,
    output logic [WORD_BITS-1:0] a_rem_out,
    output logic [WORD_BITS-1:0] b_rem_out,
    output logic [WORD_BITS-1:0] x_rem_out
);
    import mva_pkg::*;

    mva_ctl_t ctl_reg;
    logic [WORD_BITS-1:0] a_src_reg, b_src_reg, a_rem_reg, b_rem_reg, x_rem_reg;
    logic [WORD_BITS-1:0] a_rem_next, b_rem_next, x_rem_next;

    // Shift in one dividend bit and subtract m once if the remainder reached it.
    function automatic logic [WORD_BITS-1:0] step(input logic [WORD_BITS-1:0] r,
                                                  input logic bit_in,
                                                  input logic [WORD_BITS-1:0] m);
        logic [WORD_BITS:0] r2;
        logic [WORD_BITS:0] m2;
        r2 = {r, bit_in};
        m2 = {1'b0, m};
        if (r2 >= m2)
        begin
            r2 = r2 - m2;
        end
        return r2[WORD_BITS-1:0];
    endfunction

    always_comb
    begin
        a_rem_next = step(a_rem_in, a_src_in[BIT_POS], modulus);
        b_rem_next = step(b_rem_in, b_src_in[BIT_POS], modulus);
        x_rem_next = step(x_rem_in, x_src[BIT_POS], modulus);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else if (en)
        begin
            ctl_reg <= ctl_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_src_reg <= a_src_in;
            b_src_reg <= b_src_in;
            a_rem_reg <= a_rem_next;
            b_rem_reg <= b_rem_next;
            x_rem_reg <= x_rem_next;
        end
    end

    assign ctl_out   = ctl_reg;
    assign a_src_out = a_src_reg;
    assign b_src_out = b_src_reg;
    assign a_rem_out = a_rem_reg;
    assign b_rem_out = b_rem_reg;
    assign x_rem_out = x_rem_reg;

endmodule

// ===== sv/mva_alu.sv =====
// Two-stage add, subtract and negate unit on reduced residues.
// Depends on mva_pkg.
module mva_alu #(
    parameter int WORD_BITS = mva_pkg::WORD_BITS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic [WORD_BITS-1:0] modulus,
    input  mva_pkg::mva_ctl_t    ctl_in,
    input  logic [WORD_BITS-1:0] a_in,
    input  logic [WORD_BITS-1:0] b_in,
    input  logic [WORD_BITS-1:0] x_in,
    output mva_pkg::mva_ctl_t    ctl_out,
    output logic [WORD_BITS-1:0] a_out,
    output logic [WORD_BITS-1:0] x_out,
    output logic [WORD_BITS-1:0] res_out
);
    import mva_pkg::*;

    mva_ctl_t ctl1_reg, ctl2_reg;
    logic [WORD_BITS-1:0] a1_reg, x1_reg, sum_reg, pre_reg;
    logic [WORD_BITS-1:0] a2_reg, x2_reg, res_reg;
    logic [WORD_BITS-1:0] sum_next, pre_next, res_next;

    function automatic logic [WORD_BITS-1:0] add_mod(input logic [WORD_BITS-1:0] a,
                                                     input logic [WORD_BITS-1:0] b,
                                                     input logic [WORD_BITS-1:0] m);
        logic [WORD_BITS:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= {1'b0, m})
        begin
            s = s - {1'b0, m};
        end
        return s[WORD_BITS-1:0];
    endfunction

    function automatic logic [WORD_BITS-1:0] sub_mod(input logic [WORD_BITS-1:0] a,
                                                     input logic [WORD_BITS-1:0] b,
                                                     input logic [WORD_BITS-1:0] m);
        return (a >= b) ? (a - b) : (a - b + m);
    endfunction

    function automatic logic [WORD_BITS-1:0] neg_mod(input logic [WORD_BITS-1:0] a,
                                                     input logic [WORD_BITS-1:0] m);
        return (a == '0) ? '0 : (m - a);
    endfunction

    // First stage: the sum and every result that needs only one operation.
    always_comb
    begin
        sum_next = add_mod(a_in, b_in, modulus);
        case (ctl_in.func)
            FUNC_NEG:  pre_next = neg_mod(a_in, modulus);
            FUNC_SUB:  pre_next = sub_mod(a_in, b_in, modulus);
            FUNC_ADD:  pre_next = sum_next;
            FUNC_RSUB: pre_next = sub_mod(b_in, a_in, modulus);
            default:   pre_next = '0;
        endcase
    end

    // Second stage: negate the sum for the negated-sum operation.
    always_comb
    begin
        if (ctl1_reg.func == FUNC_NEGSUM)
        begin
            res_next = neg_mod(sum_reg, modulus);
        end
        else
        begin
            res_next = pre_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl1_reg <= '0;
            ctl2_reg <= '0;
        end
        else if (en)
        begin
            ctl1_reg <= ctl_in;
            ctl2_reg <= ctl1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a1_reg  <= a_in;
            x1_reg  <= x_in;
            sum_reg <= sum_next;
            pre_reg <= pre_next;
            a2_reg  <= a1_reg;
            x2_reg  <= x1_reg;
            res_reg <= res_next;
        end
    end

    assign ctl_out = ctl2_reg;
    assign a_out   = a2_reg;
    assign x_out   = x2_reg;
    assign res_out = res_reg;

endmodule

// ===== sv/mva_mul_stage.sv =====
// One half-step of the shift-and-add modular multiplier: a doubling step
// or a conditional add of a. Depends on mva_pkg.
module mva_mul_stage #(
    parameter int WORD_BITS = mva_pkg::WORD_BITS_DEF,
    parameter int BIT_POS = 0,
    parameter bit ADD_PHASE = 1'b0
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic [WORD_BITS-1:0] modulus,
    input  mva_pkg::mva_ctl_t    ctl_in,
    input  logic [WORD_BITS-1:0] a_in,
    input  logic [WORD_BITS-1:0] x_in,
    input  logic [WORD_BITS-1:0] acc_in,
    input  logic [WORD_BITS-1:0] res_in,
    output mva_pkg::mva_ctl_t    ctl_out,
    output logic [WORD_BITS-1:0] a_out,
    output logic [WORD_BITS-1:0] x_out,
    output logic [WORD_BITS-1:0] acc_out,
    output logic [WORD_BITS-1:0] res_out
);
    import mva_pkg::*;

    mva_ctl_t ctl_reg;
    logic [WORD_BITS-1:0] a_reg, x_reg, acc_reg, res_reg;
    logic [WORD_BITS-1:0] addend;
    logic [WORD_BITS:0]   sum;
    logic [WORD_BITS-1:0] acc_next;

    // Doubling adds the accumulator to itself; the add phase adds a when the
    // multiplier bit is set. Both stay below m with one subtract.
    always_comb
    begin
        if (ADD_PHASE)
        begin
            addend = x_in[BIT_POS] ? a_in : '0;
        end
        else
        begin
            addend = acc_in;
        end
        sum = {1'b0, acc_in} + {1'b0, addend};
        if (sum >= {1'b0, modulus})
        begin
            sum = sum - {1'b0, modulus};
        end
        acc_next = sum[WORD_BITS-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else if (en)
        begin
            ctl_reg <= ctl_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_reg   <= a_in;
            x_reg   <= x_in;
            acc_reg <= acc_next;
            res_reg <= res_in;
        end
    end

    assign ctl_out = ctl_reg;
    assign a_out   = a_reg;
    assign x_out   = x_reg;
    assign acc_out = acc_reg;
    assign res_out = res_reg;

endmodule

// ===== sv/modular_vector_alu.sv =====
// Top level of the modular vector ALU: config registers, pipeline chain
// and output register. Depends on mva_pkg, mva_red_stage, mva_alu,
// mva_mul_stage and modular_vector_alu_macros.svh.
//
// Usage:
//   Items enter on in_valid/in_ready with func, operand_a, operand_b and
//   last_item; each gives exactly one result on out_valid/out_ready with
//   result_value (0..m-1) and result_last.
//   Configuration: cfg_valid/cfg_ready with cfg_index (0 modulus,
//   1 multiplier) and cfg_data; cfg_ready is always high. Write only while
//   the pipeline is empty.
//   Pipeline: from accept to out_valid, an item passes WORD_BITS operand
//   reduction stages, two ALU stages, 2*WORD_BITS multiplier half-steps and
//   the output register; the first loads at accept.
//   Throughput: one item per cycle while the output is not stalled, set by the fully pipelined chain.
//   Reset: the pipeline empties, modulus becomes 2 and multiplier 1.
//   Stall: while out_valid is high and out_ready low, the whole pipeline
//   holds and in_ready is low; nothing is lost or repeated.
//   A modulus below two or an unused func code gives result_value 0.
module modular_vector_alu #(
    parameter int WORD_BITS = mva_pkg::WORD_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [mva_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [WORD_BITS-1:0]               cfg_data,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [2:0]                         func,
    input  logic [WORD_BITS-1:0]               operand_a,
    input  logic [WORD_BITS-1:0]               operand_b,
    input  logic                               last_item,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [WORD_BITS-1:0]               result_value,
    output logic                               result_last
);
    import mva_pkg::*;
    `include "modular_vector_alu_macros.svh"

    localparam int MUL_STAGES = 2 * WORD_BITS;

    logic [WORD_BITS-1:0] modulus_reg, multiplier_reg;
    logic en;

    // Reduction chain wiring.
    mva_ctl_t             r_ctl   [0:WORD_BITS];
    logic [WORD_BITS-1:0] r_a_src [0:WORD_BITS];
    logic [WORD_BITS-1:0] r_b_src [0:WORD_BITS];
    logic [WORD_BITS-1:0] r_a     [0:WORD_BITS];
    logic [WORD_BITS-1:0] r_b     [0:WORD_BITS];
    logic [WORD_BITS-1:0] r_x     [0:WORD_BITS];

    // Multiplier chain wiring.
    mva_ctl_t             m_ctl [0:MUL_STAGES];
    logic [WORD_BITS-1:0] m_a   [0:MUL_STAGES];
    logic [WORD_BITS-1:0] m_x   [0:MUL_STAGES];
    logic [WORD_BITS-1:0] m_acc [0:MUL_STAGES];
    logic [WORD_BITS-1:0] m_res [0:MUL_STAGES];

    mva_ctl_t             out_ctl_reg;
    logic [WORD_BITS-1:0] out_value_reg, out_value_next;

    // Configuration registers.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            modulus_reg    <= WORD_BITS'(2);
            multiplier_reg <= WORD_BITS'(1);
        end
        else if (cfg_valid)
        begin
            if (cfg_index == REG_MODULUS)
            begin
                modulus_reg <= cfg_data;
            end
            else if (cfg_index == REG_MULTIPLIER)
            begin
                multiplier_reg <= cfg_data;
            end
        end
    end

    // The whole chain advances unless a finished item waits at the output.
    assign en       = !out_ctl_reg.valid || out_ready;
    assign in_ready = en;

    assign r_ctl[0]   = '{valid: in_valid, func: func, last: last_item};
    assign r_a_src[0] = operand_a;
    assign r_b_src[0] = operand_b;
    assign r_a[0]     = '0;
    assign r_b[0]     = '0;
    assign r_x[0]     = '0;

    // Operand reduction, most significant bit first.
    for (genvar i = 0; i < WORD_BITS; i++)
    begin : g_red
        mva_red_stage #(
            .WORD_BITS (WORD_BITS),
            .BIT_POS   (WORD_BITS - 1 - i)
        ) u_red (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .modulus   (modulus_reg),
            .x_src     (multiplier_reg),
            .ctl_in    (r_ctl[i]),
            .a_src_in  (r_a_src[i]),
            .b_src_in  (r_b_src[i]),
            .a_rem_in  (r_a[i]),
            .b_rem_in  (r_b[i]),
            .x_rem_in  (r_x[i]),
            .ctl_out   (r_ctl[i+1]),
            .a_src_out (r_a_src[i+1]),
            .b_src_out (r_b_src[i+1]),
            .a_rem_out (r_a[i+1]),
            .b_rem_out (r_b[i+1]),
            .x_rem_out (r_x[i+1])
        );
    end

    // Add, subtract and negate operations.
    mva_alu #(
        .WORD_BITS (WORD_BITS)
    ) u_alu (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .modulus (modulus_reg),
        .ctl_in  (r_ctl[WORD_BITS]),
        .a_in    (r_a[WORD_BITS]),
        .b_in    (r_b[WORD_BITS]),
        .x_in    (r_x[WORD_BITS]),
        .ctl_out (m_ctl[0]),
        .a_out   (m_a[0]),
        .x_out   (m_x[0]),
        .res_out (m_res[0])
    );

    assign m_acc[0] = '0;

    // Shift-and-add multiplier: a doubling and an add for each bit of x.
    for (genvar j = 0; j < MUL_STAGES; j++)
    begin : g_mul
        mva_mul_stage #(
            .WORD_BITS (WORD_BITS),
            .BIT_POS   (WORD_BITS - 1 - j / 2),
            .ADD_PHASE (j % 2 == 1)
        ) u_mul (
            .clk     (clk),
            .rst_n   (rst_n),
            .en      (en),
            .modulus (modulus_reg),
            .ctl_in  (m_ctl[j]),
            .a_in    (m_a[j]),
            .x_in    (m_x[j]),
            .acc_in  (m_acc[j]),
            .res_in  (m_res[j]),
            .ctl_out (m_ctl[j+1]),
            .a_out   (m_a[j+1]),
            .x_out   (m_x[j+1]),
            .acc_out (m_acc[j+1]),
            .res_out (m_res[j+1])
        );
    end

    // Final selection and output register.
    always_comb
    begin
        if (modulus_reg < WORD_BITS'(2))
        begin
            out_value_next = '0;
        end
        else if (m_ctl[MUL_STAGES].func == FUNC_MUL)
        begin
            out_value_next = m_acc[MUL_STAGES];
        end
        else if (m_ctl[MUL_STAGES].func == FUNC_NEG || m_ctl[MUL_STAGES].func == FUNC_SUB ||
                 m_ctl[MUL_STAGES].func == FUNC_ADD || m_ctl[MUL_STAGES].func == FUNC_RSUB ||
                 m_ctl[MUL_STAGES].func == FUNC_NEGSUM)
        begin
            out_value_next = m_res[MUL_STAGES];
        end
        else
        begin
            out_value_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ctl_reg <= '0;
        end
        else if (en)
        begin
            out_ctl_reg <= m_ctl[MUL_STAGES];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_value_reg <= out_value_next;
        end
    end

    assign out_valid    = out_ctl_reg.valid;
    assign result_value = out_value_reg;
    assign result_last  = out_ctl_reg.last;

    // Checks on the result range and on stall behavior.
    `MVA_ASSERT_IMP(a_result_in_range, out_valid && (modulus_reg >= WORD_BITS'(2)),
        result_value < modulus_reg, "result not below modulus")
    `MVA_ASSERT_IMP(a_small_modulus_zero, out_valid && (modulus_reg < WORD_BITS'(2)),
        result_value == '0, "nonzero result for modulus below two")
    `MVA_ASSERT_NXT(a_stall_holds_result, out_valid && !out_ready,
        out_valid && $stable(result_value), "stalled result changed")

endmodule

// ===== sim/tb_top.sv =====
// Testbench for the modular vector ALU: directed and random items, config phases.
// Depends on mva_pkg and modular_vector_alu; self-checking through a scoreboard class.
`timescale 1ns / 100ps

module tb_top;
    import mva_pkg::*;

    localparam int W = 64;
    localparam int LATENCY = 3 * W + 3;

    // Expected residues for items in flight, plus the predictor's copy of the registers.
    class residue_scoreboard;
        logic [W-1:0] modulus_q;
        logic [W-1:0] scalar_q;
        logic [W-1:0] residue_q[$];
        logic         last_q[$];
        int           mismatches;
        int           checked;

        function new();
            modulus_q = 2;
            scalar_q = 1;
            mismatches = 0;
            checked = 0;
        endfunction

        function logic [W-1:0] add_res(logic [W-1:0] a, logic [W-1:0] b, logic [W-1:0] m);
            logic [W:0] s;
            s = {1'b0, a} + {1'b0, b};
            if (s >= {1'b0, m})
                s = s - {1'b0, m};
            return s[W-1:0];
        endfunction

        function logic [W-1:0] sub_res(logic [W-1:0] a, logic [W-1:0] b, logic [W-1:0] m);
            return (a >= b) ? a - b : a - b + m;
        endfunction

        function logic [W-1:0] neg_res(logic [W-1:0] a, logic [W-1:0] m);
            return (a == 0) ? '0 : m - a;
        endfunction

        function logic [W-1:0] residue_of(logic [2:0] f, logic [W-1:0] ra,
                                          logic [W-1:0] rb);
            logic [W-1:0]   m;
            logic [W-1:0]   a;
            logic [W-1:0]   b;
            logic [2*W-1:0] prod;
            m = modulus_q;
            if (m < 2)
                return '0;
            a = ra % m;
            b = rb % m;
            case (f)
                FUNC_NEG:    return neg_res(a, m);
                FUNC_SUB:    return sub_res(a, b, m);
                FUNC_ADD:    return add_res(a, b, m);
                FUNC_RSUB:   return sub_res(b, a, m);
                FUNC_NEGSUM: return neg_res(add_res(a, b, m), m);
                FUNC_MUL:
                begin
                    prod = {{W{1'b0}}, a} * {{W{1'b0}}, scalar_q % m};
                    prod = prod % {{W{1'b0}}, m};
                    return prod[W-1:0];
                end
                default:     return '0;
            endcase
        endfunction

        function void note_item(logic [2:0] f, logic [W-1:0] a, logic [W-1:0] b, logic l);
            residue_q.push_back(residue_of(f, a, b));
            last_q.push_back(l);
        endfunction

        function void check_result(logic [W-1:0] value, logic l);
            logic [W-1:0] ev;
            logic         el;
            if (residue_q.size() == 0)
            begin
                $error("result_value %0d arrived with no item outstanding", value);
                mismatches++;
                return;
            end
            ev = residue_q.pop_front();
            el = last_q.pop_front();
            checked++;
            if (value !== ev)
            begin
                $error("result_value: expected %0d, got %0d", ev, value);
                mismatches++;
            end
            if (l !== el)
            begin
                $error("result_last: expected %0b, got %0b", el, l);
                mismatches++;
            end
        endfunction
    endclass

    logic                      clk = 0;
    logic                      rst_n = 0;
    logic                      cfg_valid = 0;
    logic                      cfg_ready;
    logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
    logic [W-1:0]              cfg_data = '0;
    logic                      in_valid = 0;
    logic                      in_ready;
    logic [2:0]                func = '0;
    logic [W-1:0]              operand_a = '0;
    logic [W-1:0]              operand_b = '0;
    logic                      last_item = 0;
    logic                      out_valid;
    logic                      out_ready = 0;
    logic [W-1:0]              result_value;
    logic                      result_last;

    residue_scoreboard board = new();
    int items_sent = 0;
    int phases = 0;

    modular_vector_alu #(.WORD_BITS(W)) dut (.*);

    always #4 clk = ~clk;

    // Receiver: optional random stall before each result, sampled at the rising edge.
    initial
    begin
        int gap;
        @(posedge rst_n);
        forever
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
            @(negedge clk);
            if (gap != 0)
            begin
                out_ready <= 0;
                repeat (gap) @(negedge clk);
            end
            out_ready <= 1;
            do @(posedge clk); while (!out_valid);
            board.check_result(result_value, result_last);
        end
    end

    task automatic write_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [W-1:0] data);
        @(negedge clk);
        cfg_valid <= 1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge clk); while (!cfg_ready);
        if (idx == REG_MODULUS)
            board.modulus_q = data;
        else if (idx == REG_MULTIPLIER)
            board.scalar_q = data;
        @(negedge clk);
        cfg_valid <= 0;
    endtask

    task automatic drain();
        while (board.residue_q.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 8) @(posedge clk);
    endtask

    task automatic configure(logic [W-1:0] m, logic [W-1:0] x);
        drain();
        write_reg(REG_MODULUS, m);
        write_reg(REG_MULTIPLIER, x);
        phases++;
    endtask

    // Sender: optional gap, then hold valid and payload until accepted.
    task automatic send_item(logic [2:0] f, logic [W-1:0] a, logic [W-1:0] b, logic l,
                             bit no_gap);
        int gap;
        gap = no_gap ? 0 : $urandom_range(0, 6);
        if (gap != 0)
        begin
            @(negedge clk);
            in_valid <= 0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid <= 1;
        func <= f;
        operand_a <= a;
        operand_b <= b;
        last_item <= l;
        do @(posedge clk); while (!in_ready);
        board.note_item(f, a, b, l);
        items_sent++;
    endtask

    task automatic idle_sender();
        @(negedge clk);
        in_valid <= 0;
    endtask

    function automatic logic [W-1:0] rand_word();
        return {$urandom(), $urandom()};
    endfunction

    // Random residue, mostly below the modulus, sometimes edge values or out of range.
    function automatic logic [W-1:0] rand_residue(logic [W-1:0] m);
        case ($urandom_range(0, 9))
            0: return '0;
            1: return m - 1;
            2: return rand_word();
            default: return (m < 2) ? rand_word() : rand_word() % m;
        endcase
    endfunction

    task automatic random_phase(int count, logic [W-1:0] m);
        bit burst;
        burst = 1'($urandom_range(0, 1));
        for (int i = 0; i < count; i++)
            send_item(3'($urandom_range(0, 7)), rand_residue(m), rand_residue(m),
                      $urandom_range(0, 3) == 0, burst && (i < 40));
        idle_sender();
    endtask

    initial
    begin
        logic [W-1:0] m;
        logic [W-1:0] top;
        top = '1;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1;

        // Reset values: modulus two, multiplier one.
        for (int f = 0; f < 8; f++)
            send_item(3'(f), 1, 0, f[0], 0);
        idle_sender();

        // Largest modulus with operand and multiplier extremes.
        configure(top, top - 1);
        send_item(FUNC_NEG, 0, 0, 0, 0);
        send_item(FUNC_NEG, top - 1, 0, 1, 0);
        send_item(FUNC_SUB, 0, top - 1, 0, 0);
        send_item(FUNC_ADD, top - 1, top - 1, 0, 1);
        send_item(FUNC_RSUB, top - 1, 0, 1, 1);
        send_item(FUNC_NEGSUM, top - 1, 1, 0, 1);
        send_item(FUNC_MUL, top - 1, 0, 1, 0);
        send_item(FUNC_ADD, top, top, 0, 0);
        send_item(3'd6, 5, 7, 1, 0);
        send_item(3'd7, top, top, 0, 0);
        idle_sender();

        // Multiplier above the modulus, and degenerate moduli zero and one.
        configure(64'd1000003, top);
        send_item(FUNC_MUL, 999_999, 0, 1, 0);
        send_item(FUNC_MUL, top, 0, 0, 0);
        idle_sender();
        configure(0, 5);
        send_item(FUNC_ADD, 3, 4, 1, 0);
        send_item(FUNC_MUL, 3, 0, 0, 0);
        idle_sender();
        configure(1, 0);
        send_item(FUNC_NEG, 3, 0, 1, 0);
        send_item(FUNC_SUB, 0, 9, 0, 0);
        idle_sender();

        // Random phases over a spread of moduli and multipliers.
        for (int p = 0; p < 10; p++)
        begin
            case (p % 5)
                0: m = top;
                1: m = 2;
                2: m = {32'h0, $urandom()} | 2;
                3: m = rand_word() | 64'h8000_0000_0000_0000;
                default: m = rand_word();
            endcase
            configure(m, (p % 3 == 0) ? rand_word() : rand_residue(m));
            random_phase(100, m);
        end

        drain();
        $display("Checked %0d results from %0d items over %0d register settings,",
                 board.checked, items_sent, phases + 1);
        $display("with all six operations, unused codes and degenerate moduli.");
        if (board.mismatches == 0 && board.residue_q.size() == 0)
            $display("[modular_vector_alu] OK");
        else
            $display("[modular_vector_alu] ERROR");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("Timeout with %0d results outstanding.", board.residue_q.size());
        $display("[modular_vector_alu] ERROR");
        $finish;
    end
endmodule

// ===== modular_vector_alu.f =====
+incdir+sv
sv/mva_pkg.sv
sv/mva_red_stage.sv
sv/mva_alu.sv
sv/mva_mul_stage.sv
sv/modular_vector_alu.sv
sim/tb_top.sv
